>>> hw/rtl/bfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Buddy free coalescer package
// Field widths, request codes, status codes, controller states and the
// control bundle that the controller sends to the free-map memory.
// ----------------------------------------------------------------------------
package bfc_pkg;

    localparam int ORDER_W  = 4;
    localparam int ADDR_W   = 12;
    localparam int STATUS_W = 2;

    localparam logic FUNC_FREE  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK  = 2'd0,
        STATUS_BAD = 2'd1,
        STATUS_DUP = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_BUDDY,
        ST_SET,
        ST_DONE
    } fsm_state_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic wr_bit;
    } mem_ctl_t;

endpackage
`default_nettype wire

>>> hw/rtl/buddy_free_coalescer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// A bad block goes straight to the result state; a query or a free first reads its
// own free-map bit, and a merging free then reads each buddy, one order per merge.
// Items are taken one at a time, spaced by one free-map read-modify-write per
// order through the single RAM; the result register loads once the output is free.
// Reset: a clearing pass writes every free-map bit, with req_stall high; no result is
// pending after reset.
// ----------------------------------------------------------------------------
// Buddy free coalescer
// Frees buddy-system blocks with coalescing and answers free-block queries
// from a per-order free bitmap held in one synchronous RAM.
// ----------------------------------------------------------------------------
module buddy_free_coalescer_top #(
    parameter int ADDR_BITS = 12,
    parameter int MAX_ORDER = 12
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            req_valid,
    output logic                                 req_stall,
    input  wire logic                            func,
    input  wire logic [bfc_pkg::ORDER_W-1:0]     block_order,
    input  wire logic [bfc_pkg::ADDR_W-1:0]      block_address,
    output logic                                 rsp_valid,
    input  wire logic                            rsp_stall,
    output logic      [bfc_pkg::ORDER_W-1:0]     merged_order,
    output logic      [bfc_pkg::ADDR_W-1:0]      merged_address,
    output logic                                 is_free,
    output logic      [bfc_pkg::STATUS_W-1:0]    status
);

    import bfc_pkg::*;

    localparam int DEPTH = (MAX_ORDER >= ADDR_BITS)
                         ? ((1 << (ADDR_BITS + 1)) - 1 + MAX_ORDER - ADDR_BITS)
                         : ((1 << (ADDR_BITS + 1)) - (1 << (ADDR_BITS - MAX_ORDER)));
    localparam int IDX_W = $clog2(DEPTH);

    mem_ctl_t           mem_ctl;
    logic [IDX_W-1:0]   rd_idx;
    logic [IDX_W-1:0]   wr_idx;
    logic               rd_data;

    bfc_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_free_map (
        .clk     (clk),
        .wr_en   (mem_ctl.wr_en),
        .wr_addr (wr_idx),
        .wr_data (mem_ctl.wr_bit),
        .rd_en   (mem_ctl.rd_en),
        .rd_addr (rd_idx),
        .rd_data (rd_data)
    );

    bfc_ctrl #(
        .ADDR_BITS (ADDR_BITS),
        .MAX_ORDER (MAX_ORDER),
        .DEPTH     (DEPTH),
        .IDX_W     (IDX_W)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .func           (func),
        .block_order    (block_order),
        .block_address  (block_address),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .merged_order   (merged_order),
        .merged_address (merged_address),
        .is_free        (is_free),
        .status         (status),
        .mem_ctl        (mem_ctl),
        .rd_idx         (rd_idx),
        .wr_idx         (wr_idx),
        .rd_data        (rd_data)
    );

`ifndef SYNTHESIS
    // The buddy clear and the next-order read always touch different entries.
    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_ctl.wr_en && mem_ctl.rd_en) |-> (wr_idx != rd_idx))
        else $error("free map read and write hit the same entry");

    a_error_no_block: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status != STATUS_OK) |-> (merged_order == '0 && merged_address == '0))
        else $error("rejected item reports a merged block");

    a_query_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && is_free) |->
        (status == STATUS_OK && merged_order == '0 && merged_address == '0))
        else $error("query result carries free-path fields");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/bfc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bfc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

>>> hw/rtl/bfc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Buddy free coalescer controller
// Sequencer that clears the free map, checks each item, climbs the orders
// with one read-modify-write of the free map per order, and holds the result.
// ----------------------------------------------------------------------------
module bfc_ctrl #(
    parameter int ADDR_BITS = 12,
    parameter int MAX_ORDER = 12,
    parameter int DEPTH     = 8191,
    parameter int IDX_W     = 13
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            req_valid,
    output logic                                 req_stall,
    input  wire logic                            func,
    input  wire logic [bfc_pkg::ORDER_W-1:0]     block_order,
    input  wire logic [bfc_pkg::ADDR_W-1:0]      block_address,
    output logic                                 rsp_valid,
    input  wire logic                            rsp_stall,
    output logic      [bfc_pkg::ORDER_W-1:0]     merged_order,
    output logic      [bfc_pkg::ADDR_W-1:0]      merged_address,
    output logic                                 is_free,
    output logic      [bfc_pkg::STATUS_W-1:0]    status,
    output bfc_pkg::mem_ctl_t                    mem_ctl,
    output logic      [IDX_W-1:0]                rd_idx,
    output logic      [IDX_W-1:0]                wr_idx,
    input  wire logic                            rd_data
);

    import bfc_pkg::*;

    localparam int K_W = $clog2(MAX_ORDER + 1);
    localparam int BW  = IDX_W + 1;
    localparam logic [BW-1:0] FULL     = BW'(1) << (ADDR_BITS + 1);
    localparam logic [BW-1:0] TOP_BASE = FULL - BW'(2);

    // Orders below ADDR_BITS hold one bit per block; each order from ADDR_BITS up holds
    // a single bit for the block at address zero.
    function automatic logic [IDX_W-1:0] map_idx(input logic [K_W-1:0] k,
                                                 input logic [ADDR_W-1:0] off);
        logic [BW-1:0] base;
        if (int'(k) >= ADDR_BITS)
        begin
            base = TOP_BASE + BW'(k) - BW'(ADDR_BITS);
            return IDX_W'(base);
        end
        base = FULL - (FULL >> k);
        return IDX_W'(base + BW'(off));
    endfunction

    fsm_state_t           state_reg, state_next;
    logic [IDX_W-1:0]     clr_cnt_reg, clr_cnt_next;
    logic                 func_reg, func_next;
    logic [K_W-1:0]       k_reg, k_next;
    logic [ADDR_W-1:0]    addr_reg, addr_next;
    status_t              status_reg, status_next;
    logic                 is_free_reg, is_free_next;
    logic                 freed_reg, freed_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    logic [ORDER_W-1:0]   rsp_order_reg, rsp_order_next;
    logic [ADDR_W-1:0]    rsp_addr_reg, rsp_addr_next;
    logic                 rsp_is_free_reg, rsp_is_free_next;
    status_t              rsp_status_reg, rsp_status_next;

    logic                 req_bad;
    logic [ADDR_W-1:0]    align_mask;
    logic [IDX_W-1:0]     in_idx;
    logic [IDX_W-1:0]     self_idx;
    logic [IDX_W-1:0]     buddy_idx;
    logic [IDX_W-1:0]     up_buddy_idx;
    logic [K_W-1:0]       up_k;
    logic [ADDR_W-1:0]    up_addr;
    logic                 can_merge_cur;
    logic                 can_merge_up;
    logic                 rsp_free;

    assign align_mask = ~({ADDR_W{1'b1}} << block_order);
    assign req_bad    = (int'(block_order) > MAX_ORDER)
                     || ((int'(block_address) >> ADDR_BITS) != 0)
                     || ((block_address & align_mask) != '0);
    assign in_idx     = map_idx(K_W'(block_order), block_address >> block_order);

    assign up_k          = k_reg + K_W'(1);
    assign up_addr       = addr_reg & ~(ADDR_W'(1) << k_reg);
    assign self_idx      = map_idx(k_reg, addr_reg >> k_reg);
    assign buddy_idx     = map_idx(k_reg, (addr_reg >> k_reg) ^ ADDR_W'(1));
    assign up_buddy_idx  = map_idx(up_k, (up_addr >> up_k) ^ ADDR_W'(1));
    assign can_merge_cur = (int'(k_reg) < MAX_ORDER) && (int'(k_reg) < ADDR_BITS);
    assign can_merge_up  = (int'(up_k) < MAX_ORDER) && (int'(up_k) < ADDR_BITS);
    assign rsp_free      = !rsp_valid_reg || !rsp_stall;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == IDX_W'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = req_bad ? ST_DONE : ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (func_reg == FUNC_QUERY || rd_data || !can_merge_cur)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_BUDDY;
                end
            end
            ST_BUDDY:
            begin
                if (!rd_data)
                begin
                    state_next = ST_DONE;
                end
                else if (!can_merge_up)
                begin
                    state_next = ST_SET;
                end
            end
            ST_SET:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Memory port and request handshake.
    always_comb
    begin
        req_stall      = 1'b1;
        mem_ctl.rd_en  = 1'b0;
        mem_ctl.wr_en  = 1'b0;
        mem_ctl.wr_bit = 1'b1;
        rd_idx         = in_idx;
        wr_idx         = self_idx;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_ctl.wr_en  = 1'b1;
                mem_ctl.wr_bit = 1'b0;
                wr_idx         = clr_cnt_reg;
            end
            ST_IDLE:
            begin
                req_stall     = 1'b0;
                mem_ctl.rd_en = req_valid && !req_bad;
            end
            ST_CHECK:
            begin
                if (func_reg == FUNC_FREE && !rd_data)
                begin
                    if (can_merge_cur)
                    begin
                        mem_ctl.rd_en = 1'b1;
                        rd_idx        = buddy_idx;
                    end
                    else
                    begin
                        mem_ctl.wr_en = 1'b1;
                    end
                end
            end
            ST_BUDDY:
            begin
                mem_ctl.wr_en = 1'b1;
                if (rd_data)
                begin
                    // Take the buddy off its order and look one order up.
                    mem_ctl.wr_bit = 1'b0;
                    wr_idx         = buddy_idx;
                    mem_ctl.rd_en  = can_merge_up;
                    rd_idx         = up_buddy_idx;
                end
            end
            ST_SET:
            begin
                mem_ctl.wr_en = 1'b1;
            end
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Item datapath and result register.
    always_comb
    begin
        clr_cnt_next     = clr_cnt_reg;
        func_next        = func_reg;
        k_next           = k_reg;
        addr_next        = addr_reg;
        status_next      = status_reg;
        is_free_next     = is_free_reg;
        freed_next       = freed_reg;
        rsp_valid_next   = rsp_valid_reg && rsp_stall;
        rsp_order_next   = rsp_order_reg;
        rsp_addr_next    = rsp_addr_reg;
        rsp_is_free_next = rsp_is_free_reg;
        rsp_status_next  = rsp_status_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + IDX_W'(1);
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    func_next    = func;
                    k_next       = K_W'(block_order);
                    addr_next    = block_address;
                    status_next  = req_bad ? STATUS_BAD : STATUS_OK;
                    is_free_next = 1'b0;
                    freed_next   = 1'b0;
                end
            end
            ST_CHECK:
            begin
                if (func_reg == FUNC_QUERY)
                begin
                    is_free_next = rd_data;
                end
                else if (rd_data)
                begin
                    status_next = STATUS_DUP;
                end
                else if (!can_merge_cur)
                begin
                    freed_next = 1'b1;
                end
            end
            ST_BUDDY:
            begin
                if (!rd_data)
                begin
                    freed_next = 1'b1;
                end
                else
                begin
                    k_next    = up_k;
                    addr_next = up_addr;
                end
            end
            ST_SET:
            begin
                freed_next = 1'b1;
            end
            ST_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next   = 1'b1;
                    rsp_order_next   = freed_reg ? ORDER_W'(k_reg) : '0;
                    rsp_addr_next    = freed_reg ? addr_reg : '0;
                    rsp_is_free_next = is_free_reg;
                    rsp_status_next  = status_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg        <= func_next;
        k_reg           <= k_next;
        addr_reg        <= addr_next;
        status_reg      <= status_next;
        is_free_reg     <= is_free_next;
        freed_reg       <= freed_next;
        rsp_order_reg   <= rsp_order_next;
        rsp_addr_reg    <= rsp_addr_next;
        rsp_is_free_reg <= rsp_is_free_next;
        rsp_status_reg  <= rsp_status_next;
    end

    assign rsp_valid      = rsp_valid_reg;
    assign merged_order   = rsp_order_reg;
    assign merged_address = rsp_addr_reg;
    assign is_free        = rsp_is_free_reg;
    assign status         = rsp_status_reg;

endmodule
`default_nettype wire
